@@ sv/scta_pkg.sv @@
// Package: item types, command and register codes, and shared constants for the curve table.
`default_nettype none
package scta_pkg;

	// number of distinct driving codes (12-bit codes)
	localparam int DDL_SPAN = 4096;

	localparam logic [11:0] MAX_DDL_RESET = 12'd255;
	localparam logic DEVICE_KIND_RESET = 1'b0;

	// commands carried by an input item
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_FINAL = 2'd1,
		CMD_NEAR  = 2'd2,
		CMD_INDEX = 2'd3
	} cmd_t;

	// configuration register indexes
	localparam logic REG_DEVICE_KIND = 1'b0;
	localparam logic REG_MAX_DDL     = 1'b1;

	typedef struct packed {
		cmd_t               command;
		logic [15:0]        code;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic        status;
		logic [11:0] position;
		logic [11:0] code_out;
		logic [30:0] value_out;
		logic [12:0] entry_count;
		logic [30:0] min_value;
		logic [30:0] max_value;
		logic        monotone;
	} out_item_t;

	// result of the shared compare / distance unit
	typedef struct packed {
		logic        lt;
		logic        gt;
		logic [32:0] mag;
	} alu_res_t;

endpackage
`default_nettype wire

@@ sv/scta_ram.sv @@
// Module: generic RAM with one write port and one registered read port (read-before-write).
`default_nettype none
module scta_ram #(
	parameter int W = 32,
	parameter int D = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule
`default_nettype wire

@@ sv/scta_alu.sv @@
// Module: shared signed subtract unit giving less, greater and absolute distance.
`default_nettype none
module scta_alu (
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output scta_pkg::alu_res_t      res
);
	import scta_pkg::*;

	logic signed [32:0] diff;

	// one 33-bit subtract feeds both the compare and the magnitude
	always_comb begin
		diff    = {a[31], a} - {b[31], b};
		res.lt  = diff[32];
		res.gt  = ~diff[32] & (|diff);
		res.mag = diff[32] ? (~diff + 33'sd1) : diff;
	end

endmodule
`default_nettype wire

@@ sv/sorted_curve_table_nearest_lookup.sv @@
// Module: top level of the sorted curve table with nearest-value lookup.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | in_item  (command, code, value)
//  out     | output    | out_valid / out_stall | out_item (status ... monotone)
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// Finalize sweeps every staging slot through one RAM port (ENTRIES = min(TABLE_DEPTH, 4096)).
// Value query walks the table one entry per cycle through the shared compare unit.
// An index query reads the table at the given position; an out-of-range position skips the read.
// After reset a clearing pass over every staging slot of the ENTRIES slots holds in_stall.
// A finished result waits in the output register while the next item is taken.
`default_nettype none
module sorted_curve_table_nearest_lookup #(
	parameter int TABLE_DEPTH = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire scta_pkg::in_item_t   in_item,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output scta_pkg::out_item_t       out_item,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [11:0]          cfg_data
);
	import scta_pkg::*;

	localparam int ENTRIES = (TABLE_DEPTH < DDL_SPAN) ? TABLE_DEPTH : DDL_SPAN;
	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int TW = 31 + AW;
	localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

	typedef enum logic [9:0] {
		ST_CLR    = 10'b0000000001,
		ST_IDLE   = 10'b0000000010,
		ST_FSCAN  = 10'b0000000100,
		ST_FDRAIN = 10'b0000001000,
		ST_FDONE  = 10'b0000010000,
		ST_QSCAN  = 10'b0000100000,
		ST_QTIE   = 10'b0001000000,
		ST_IRD    = 10'b0010000000,
		ST_IOUT   = 10'b0100000000,
		ST_EMIT   = 10'b1000000000
	} state_t;

	// control registers
	state_t          state_q;
	logic            device_kind_q;
	logic [11:0]     max_ddl_q;
	logic [AW-1:0]   addr_q;
	logic            vld_s1;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   count_q;
	logic            out_valid_q;

	// datapath registers
	logic [AW-1:0]      idx_s1;
	logic               inr_s1;
	logic [30:0]        mn_q;
	logic [30:0]        mx_q;
	logic               mono_q;
	logic [30:0]        prev_val_q;
	logic [AW-1:0]      prev_code_q;
	logic [AW-1:0]      cur_code_q;
	logic [AW-1:0]      idx_q;
	logic [32:0]        abs_cur_q;
	logic signed [31:0] value_q;
	out_item_t          res_q;
	out_item_t          out_q;

	// memories and shared unit
	logic            st_we;
	logic [AW-1:0]   st_addr;
	logic [31:0]     st_wdata;
	logic [31:0]     st_rdata;
	logic            tb_we;
	logic [TW-1:0]   tb_rdata;
	logic signed [31:0] alu_a;
	alu_res_t        alu;

	logic            in_acc;
	logic            load_ok;
	logic [30:0]     load_val;
	logic [30:0]     st_val;
	logic            st_ok;
	logic [30:0]     tb_val;
	logic [AW-1:0]   tb_code;
	logic            fin_take;
	logic            mono_fail;
	logic            q_cont;
	logic            q_last;
	logic            q_stop;
	logic            emit_go;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// load qualification and clamping of negative values
	assign load_ok  = (17'(in_item.code) < 17'(ENTRIES)) && (in_item.code <= 16'(max_ddl_q));
	assign load_val = in_item.value[31] ? 31'd0 : in_item.value[30:0];

	// staging port: loads in idle, clearing writes during sweeps
	always_comb begin
		st_addr  = (state_q == ST_IDLE) ? in_item.code[AW-1:0] : addr_q;
		st_we    = 1'b0;
		st_wdata = '0;
		if (state_q == ST_CLR || state_q == ST_FSCAN) begin
			st_we = 1'b1;
		end else if (in_acc && in_item.command == CMD_LOAD && load_ok) begin
			st_we    = 1'b1;
			st_wdata = {1'b1, load_val};
		end
	end

	scta_ram #(.W(32), .D(ENTRIES)) u_stage (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_addr),
		.wdata (st_wdata),
		.raddr (st_addr),
		.rdata (st_rdata)
	);

	assign st_ok  = st_rdata[31];
	assign st_val = st_rdata[30:0];

	// a staged slot joins the table when set and within the code limit
	assign fin_take = vld_s1 & inr_s1 & st_ok &
		((state_q == ST_FSCAN) | (state_q == ST_FDRAIN));
	assign tb_we = fin_take;

	scta_ram #(.W(TW), .D(ENTRIES)) u_table (
		.clk   (clk),
		.we    (tb_we),
		.waddr (n_q[AW-1:0]),
		.wdata ({st_val, idx_s1}),
		.raddr (addr_q),
		.rdata (tb_rdata)
	);

	assign tb_val  = tb_rdata[TW-1:AW];
	assign tb_code = tb_rdata[AW-1:0];

	// shared compare unit: scan compare, then the tie check against the previous entry
	assign alu_a = (state_q == ST_QTIE) ? signed'({1'b0, prev_val_q}) : signed'({1'b0, tb_val});

	scta_alu u_alu (
		.a   (alu_a),
		.b   (value_q),
		.res (alu)
	);

	assign mono_fail = device_kind_q ? (prev_val_q < st_val) : (prev_val_q > st_val);
	assign q_cont    = device_kind_q ? alu.gt : alu.lt;
	assign q_last    = ((CW'(idx_s1) + CW'(1)) == count_q);
	assign q_stop    = vld_s1 & (state_q == ST_QSCAN) & (q_last | ~q_cont);
	assign emit_go   = (state_q == ST_EMIT) & (~out_valid_q | ~out_stall);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_kind_q <= DEVICE_KIND_RESET;
			max_ddl_q     <= MAX_DDL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEVICE_KIND: device_kind_q <= cfg_data[0];
				REG_MAX_DDL:     max_ddl_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_q <= res_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			addr_q  <= '0;
			vld_s1  <= 1'b0;
			n_q     <= '0;
			count_q <= '0;
		end else begin
			if (fin_take) begin
				n_q <= n_q + CW'(1);
			end
			case (state_q)
				ST_CLR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (in_acc) begin
						case (in_item.command)
							CMD_FINAL: begin
								addr_q  <= '0;
								n_q     <= '0;
								state_q <= ST_FSCAN;
							end
							CMD_NEAR: begin
								addr_q  <= '0;
								state_q <= (count_q == '0) ? ST_EMIT : ST_QSCAN;
							end
							CMD_INDEX: begin
								addr_q  <= in_item.code[AW-1:0];
								state_q <= (in_item.code < 16'(count_q)) ? ST_IRD : ST_EMIT;
							end
							default: ;
						endcase
					end
				end
				ST_FSCAN: begin
					vld_s1 <= 1'b1;
					addr_q <= addr_q + AW'(1);
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_FDRAIN;
					end
				end
				ST_FDRAIN: begin
					vld_s1  <= 1'b0;
					state_q <= ST_FDONE;
				end
				ST_FDONE: begin
					count_q <= n_q;
					state_q <= ST_EMIT;
				end
				ST_QSCAN: begin
					vld_s1 <= 1'b1;
					addr_q <= addr_q + AW'(1);
					if (q_stop) begin
						vld_s1  <= 1'b0;
						state_q <= (idx_s1 == '0) ? ST_EMIT : ST_QTIE;
					end
				end
				ST_QTIE: state_q <= ST_EMIT;
				ST_IRD:  state_q <= ST_IOUT;
				ST_IOUT: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: scan tracking, extremes, direction check and result assembly
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		inr_s1 <= (12'(addr_q) <= max_ddl_q);
		if (fin_take) begin
			prev_val_q <= st_val;
			if (n_q == '0) begin
				mn_q <= st_val;
				mx_q <= st_val;
			end else begin
				if (st_val < mn_q) mn_q <= st_val;
				if (st_val > mx_q) mx_q <= st_val;
				if (mono_fail) mono_q <= 1'b0;
			end
		end
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					value_q <= in_item.value;
					res_q   <= '0;
					mono_q  <= 1'b1;
					mn_q    <= '0;
					mx_q    <= '0;
					// empty table or out-of-range position answers at once
					if ((in_item.command == CMD_NEAR && count_q == '0) ||
					    (in_item.command == CMD_INDEX && in_item.code >= 16'(count_q))) begin
						res_q.status <= 1'b1;
					end
				end
			end
			ST_FDONE: begin
				res_q.status      <= (n_q == '0);
				res_q.entry_count <= 13'(n_q);
				res_q.min_value   <= mn_q;
				res_q.max_value   <= mx_q;
				res_q.monotone    <= mono_q;
			end
			ST_QSCAN: begin
				if (vld_s1) begin
					if (q_stop) begin
						abs_cur_q      <= alu.mag;
						cur_code_q     <= tb_code;
						idx_q          <= idx_s1;
						res_q.position <= 12'(idx_s1);
						res_q.code_out <= 12'(tb_code);
					end else begin
						prev_val_q  <= tb_val;
						prev_code_q <= tb_code;
					end
				end
			end
			ST_QTIE: begin
				// ties stay on the upper entry
				if (alu.mag < abs_cur_q) begin
					res_q.position <= 12'(idx_q - AW'(1));
					res_q.code_out <= 12'(prev_code_q);
				end else begin
					res_q.position <= 12'(idx_q);
					res_q.code_out <= 12'(cur_code_q);
				end
			end
			ST_IOUT: res_q.value_out <= tb_val;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

@@ sv/scta_chk.sv @@
// Module: port-level checker for the curve table, bound to the top level.
`default_nettype none
module scta_chk (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire scta_pkg::in_item_t  in_item,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire scta_pkg::out_item_t out_item
);
	import scta_pkg::*;

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// any command other than load keeps the block busy for the next cycle
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.command != CMD_LOAD |=> in_stall)
		else $error("input not stalled after a table command");

	// a new result is only produced while the input side is busy
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

	// a finalized non-empty table reports ok and ordered extremes
	a_count_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.entry_count != 13'd0 |-> !out_item.status)
		else $error("non-empty table reported as empty");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.entry_count != 13'd0 |->
		out_item.min_value <= out_item.max_value)
		else $error("minimum above maximum");

endmodule

bind sorted_curve_table_nearest_lookup scta_chk u_scta_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
`default_nettype wire
